// File: rtl/sfr_pkg.sv
// Shared types and constants for the streaming find-and-replace block.
// No dependencies; every other file but sfr_ifs imports this package.
package sfr_pkg;

   localparam int MaxSearch  = 16;
   localparam int MaxReplace = 16;
   localparam int LenWidth   = 5;
   localparam int IdxWidth   = 4;
   localparam int QueueDepth = 4;
   localparam int QPtrWidth  = 2;
   localparam int QCntWidth  = 3;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_SEARCH_LOW   = 3'd0,
      REG_SEARCH_HIGH  = 3'd1,
      REG_SEARCH_LEN   = 3'd2,
      REG_REPLACE_LOW  = 3'd3,
      REG_REPLACE_HIGH = 3'd4,
      REG_REPLACE_LEN  = 3'd5
   } reg_index_type;

   // What the back end has to do for one queued command
   typedef enum logic [1:0] {
      CMD_POP     = 2'd0,   // emit the oldest window bytes
      CMD_REPLACE = 2'd1,   // emit the replacement string
      CMD_EMPTY   = 2'd2    // one empty end marker
   } cmd_kind_type;

   // Effective configuration, lengths already clamped
   typedef struct packed {
      logic [MaxSearch-1:0][7:0]  search_bytes;
      logic [LenWidth-1:0]        search_len;
      logic [MaxReplace-1:0][7:0] replace_bytes;
      logic [LenWidth-1:0]        replace_len;
   } cfg_type;

   // Command passed from the front end to the back end
   typedef struct packed {
      cmd_kind_type              kind;
      logic [LenWidth-1:0]       count;   // results to emit, 1..16
      logic                      fin;
      logic [MaxSearch-1:0][7:0] bytes;   // window snapshot, oldest at 0
   } cmd_type;

endpackage

// File: rtl/sfr_ifs.sv
// Valid/ready channel interfaces for the request and response streams.
// Standalone; used by the top level and its front and back ends.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;

   modport source (output valid, output data_byte, output is_final, input ready);
   modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       run_last;
   logic       stream_end;

   modport source (output valid, output out_byte, output has_byte,
                   output run_last, output stream_end, input ready);
   modport sink   (input valid, input out_byte, input has_byte,
                   input run_last, input stream_end, output ready);
endinterface

// File: rtl/stream_find_replace.sv
// Streaming find-and-replace, top level: register file, front end, queue, back end.
// Depends on sfr_pkg, sfr_ifs, sfr_front, sfr_cmd_queue and sfr_back.
//
// The block takes one byte per cycle and replaces every leftmost, non-overlapping
// occurrence of the programmed search string (1..16 bytes) with the replacement
// string (0..16 bytes). Input bytes are accepted every cycle while the four-entry
// command queue has room; commands pass the queue, results the output register.
// The output side delivers one result byte per cycle while the receiver is ready,
// so an item with several results (a replacement or a final flush, up to 16 each)
// holds the back end until all are out; the queue absorbs such bursts, sustaining
// one item per cycle if each causes at most one result and the receiver is ready.
// Write the configuration registers only while no transfer is outstanding.
module stream_find_replace
   import sfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sfr_req_if.sink     req_chan,
   sfr_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   logic [63:0]         search_low_ff, search_high_ff;
   logic [63:0]         replace_low_ff, replace_high_ff;
   logic [LenWidth-1:0] search_len_ff, replace_len_ff;

   cfg_type cfg;
   logic    q_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         search_low_ff   <= '0;
         search_high_ff  <= '0;
         search_len_ff   <= LenWidth'(1);
         replace_low_ff  <= '0;
         replace_high_ff <= '0;
         replace_len_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SEARCH_LOW:   search_low_ff   <= csr_wr_data;
            REG_SEARCH_HIGH:  search_high_ff  <= csr_wr_data;
            REG_SEARCH_LEN:   search_len_ff   <= csr_wr_data[LenWidth-1:0];
            REG_REPLACE_LOW:  replace_low_ff  <= csr_wr_data;
            REG_REPLACE_HIGH: replace_high_ff <= csr_wr_data;
            REG_REPLACE_LEN:  replace_len_ff  <= csr_wr_data[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   // Effective lengths: zero search acts as one, both clamp at the maximum
   always_comb begin
      cfg.search_bytes  = {search_high_ff, search_low_ff};
      cfg.replace_bytes = {replace_high_ff, replace_low_ff};
      if (search_len_ff == '0) begin
         cfg.search_len = LenWidth'(1);
      end else if (search_len_ff > LenWidth'(MaxSearch)) begin
         cfg.search_len = LenWidth'(MaxSearch);
      end else begin
         cfg.search_len = search_len_ff;
      end
      if (replace_len_ff > LenWidth'(MaxReplace)) begin
         cfg.replace_len = LenWidth'(MaxReplace);
      end else begin
         cfg.replace_len = replace_len_ff;
      end
   end

   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   sfr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

// File: rtl/sfr_front.sv
// Front end: holds the match window, compares it and queues at most one command per item.
// Depends on sfr_pkg and sfr_req_if.
module sfr_front
   import sfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   sfr_req_if.sink req,
   input  logic    q_full,
   output logic    push_valid,
   output cmd_type push_cmd
);

   logic [LenWidth-1:0]       fill_ff, fill_in;
   logic [MaxSearch-1:0][7:0] win_ff, win_in;

   logic [MaxSearch-1:0][7:0] win_app;
   logic [LenWidth-1:0]       new_fill;
   logic [LenWidth-1:0]       pops;
   logic [MaxSearch-1:0]      byte_ok;
   logic                      match;
   logic                      accept;
   logic [LenWidth:0]         src_idx;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // Append, compare and classify
   always_comb begin
      new_fill = fill_ff + LenWidth'(1);
      for (int j = 0; j < MaxSearch; j++) begin
         win_app[j] = (IdxWidth'(j) == fill_ff[IdxWidth-1:0]) ? req.data_byte : win_ff[j];
         byte_ok[j] = (win_app[j] == cfg.search_bytes[j]) ||
                      (LenWidth'(j) >= cfg.search_len);
      end
      match = (new_fill == cfg.search_len) && (&byte_ok);

      if (match) begin
         pops = '0;
      end else if (req.is_final) begin
         pops = new_fill;
      end else if (new_fill == cfg.search_len) begin
         pops = LenWidth'(1);
      end else if (new_fill > cfg.search_len) begin
         // search length was shrunk: drain down to one short of it
         pops = new_fill - cfg.search_len + LenWidth'(1);
      end else begin
         pops = '0;
      end

      push_cmd.fin   = req.is_final;
      push_cmd.bytes = win_app;
      if (match && cfg.replace_len != '0) begin
         push_cmd.kind  = CMD_REPLACE;
         push_cmd.count = cfg.replace_len;
      end else if (match) begin
         push_cmd.kind  = CMD_EMPTY;
         push_cmd.count = LenWidth'(1);
      end else begin
         push_cmd.kind  = CMD_POP;
         push_cmd.count = pops;
      end
      push_valid = accept && (match ? (cfg.replace_len != '0 || req.is_final) : (pops != '0));

      // Window after the step
      for (int j = 0; j < MaxSearch; j++) begin
         src_idx   = (LenWidth+1)'(j) + {1'b0, pops};
         win_in[j] = (src_idx < (LenWidth+1)'(MaxSearch)) ? win_app[src_idx[IdxWidth-1:0]] : 8'h00;
      end
      if (match || req.is_final) begin
         fill_in = '0;
      end else begin
         fill_in = new_fill - pops;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   // Between items the window always holds fewer than MaxSearch bytes
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LenWidth'(MaxSearch - 1))
      else $error("window fill out of range");

endmodule

// File: rtl/sfr_cmd_queue.sv
// Short command FIFO between the front and back ends.
// Depends on sfr_pkg.
module sfr_cmd_queue
   import sfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    q_full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type                entries_ff [QueueDepth];
   logic [QPtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCntWidth-1:0]   count_ff, count_in;

   assign q_full     = (count_ff == QCntWidth'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QCntWidth'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCntWidth'(1);
      end
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + QPtrWidth'(1);
         if (pop)        rd_ptr_ff <= rd_ptr_ff + QPtrWidth'(1);
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command queue underflow");

endmodule

// File: rtl/sfr_back.sv
// Back end: expands queued commands into result bytes, one per cycle while the receiver is ready.
// Depends on sfr_pkg and sfr_rsp_if.
module sfr_back
   import sfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    head_valid,
   input  cmd_type head_cmd,
   output logic    pop,
   sfr_rsp_if.source rsp
);

   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff;
   logic                rsp_has_byte_ff;
   logic                rsp_run_last_ff;
   logic                rsp_stream_end_ff;

   logic                out_free;
   logic                issue;
   logic                last;
   logic [7:0]          sel_byte;

   // Pick the next result
   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      issue    = head_valid && out_free;
      last     = ({1'b0, idx_ff} + LenWidth'(1)) == head_cmd.count;
      pop      = issue && last;

      unique case (head_cmd.kind)
         CMD_POP:     sel_byte = head_cmd.bytes[idx_ff];
         CMD_REPLACE: sel_byte = cfg.replace_bytes[idx_ff];
         default:     sel_byte = 8'h00;
      endcase

      idx_in = idx_ff;
      if (issue) begin
         idx_in = last ? '0 : idx_ff + IdxWidth'(1);
      end

      rsp_valid_in = issue ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_byte_ff       <= sel_byte;
         rsp_has_byte_ff   <= (head_cmd.kind != CMD_EMPTY);
         rsp_run_last_ff   <= last;
         rsp_stream_end_ff <= last && head_cmd.fin;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = rsp_byte_ff;
   assign rsp.has_byte   = rsp_has_byte_ff;
   assign rsp.run_last   = rsp_run_last_ff;
   assign rsp.stream_end = rsp_stream_end_ff;

   // An empty marker only ever closes a stream
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_byte_ff |-> rsp_stream_end_ff && rsp_run_last_ff)
      else $error("empty result without end mark");

   a_empty_cmd_final: assert property (@(posedge clock) disable iff (reset)
      issue && head_cmd.kind == CMD_EMPTY |-> head_cmd.fin)
      else $error("empty command on a non-final item");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for stream_find_replace: directed and random byte streams,
// predicted on acceptance and checked result by result on the response channel.
// Depends on sfr_pkg, sfr_ifs and the stream_find_replace RTL.
module tb_top;
   import sfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // One input byte waiting to be driven
   typedef struct {
      logic [7:0] data_byte;
      logic       is_final;
      bit         drain_first;   // hold until every expected result has arrived
   } text_item_type;

   // One expected result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       stream_end;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [63:0] csr_wr_data = 64'd0;

   sfr_req_if req_if ();
   sfr_rsp_if rsp_if ();

   stream_find_replace u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_item_type text_in_q[$];
   result_type    rewritten_q[$];
   int            mismatch_count = 0;
   int            items_queued = 0;

   // Predictor copy of the registers, reset values
   logic [63:0] cfg_search_lo = 64'd0;
   logic [63:0] cfg_search_hi = 64'd0;
   logic [4:0]  cfg_search_len = 5'd1;
   logic [63:0] cfg_replace_lo = 64'd0;
   logic [63:0] cfg_replace_hi = 64'd0;
   logic [4:0]  cfg_replace_len = 5'd0;

   // Predictor window, oldest byte at index 0
   logic [7:0]  win_bytes [16] = '{default: 8'h00};
   logic [4:0]  win_fill = 5'd0;
   result_type  step_out[$];

   function automatic logic [7:0] string_byte(logic [63:0] lo, logic [63:0] hi, int k);
      k = k & 15;
      return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
   endfunction

   // Emit the oldest window byte and shift the rest down
   function automatic void pop_window();
      if (win_fill == 5'd0) return;
      step_out.push_back('{win_bytes[0], 1'b1, 1'b0, 1'b0});
      for (int k = 1; k < 16; k++) win_bytes[k-1] = win_bytes[k];
      win_bytes[15] = 8'h00;
      win_fill--;
   endfunction

   // Expected results for one accepted byte
   function automatic void rewrite_step(logic [7:0] b, logic fin);
      int         slen;
      int         rlen;
      bit         hit;
      result_type tail;
      slen = (cfg_search_len == 5'd0) ? 1 :
             (cfg_search_len > MaxSearch) ? MaxSearch : int'(cfg_search_len);
      rlen = (cfg_replace_len > MaxReplace) ? MaxReplace : int'(cfg_replace_len);
      step_out.delete();

      if (win_fill >= 5'd16) pop_window();
      win_bytes[win_fill[3:0]] = b;
      win_fill++;

      if (win_fill == slen) begin
         hit = 1'b1;
         for (int k = 0; k < slen; k++)
            if (win_bytes[k] != string_byte(cfg_search_lo, cfg_search_hi, k)) hit = 1'b0;
         if (hit) begin
            for (int k = 0; k < rlen; k++)
               step_out.push_back('{string_byte(cfg_replace_lo, cfg_replace_hi, k),
                                    1'b1, 1'b0, 1'b0});
            win_bytes = '{default: 8'h00};
            win_fill  = 5'd0;
         end else begin
            pop_window();
         end
      end else begin
         // window longer than the search string after a shrink: no compare
         while (win_fill > slen) pop_window();
         if (win_fill == slen) pop_window();
      end

      // final byte flushes the window; an empty step still marks the end
      if (fin) begin
         while (win_fill > 5'd0) pop_window();
         win_bytes = '{default: 8'h00};
         win_fill  = 5'd0;
         if (step_out.size() == 0) step_out.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      end

      if (step_out.size() > 0) begin
         tail = step_out.pop_back();
         tail.run_last   = 1'b1;
         tail.stream_end = fin;
         step_out.push_back(tail);
      end
      foreach (step_out[k]) rewritten_q.push_back(step_out[k]);
   endfunction

   // Request driver: bursts of random length with random gaps
   int            burst_left = 0;
   int            gap_left = 0;
   text_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) rewrite_step(req_if.data_byte, req_if.is_final);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (text_in_q.size() > 0 &&
                         !(text_in_q[0].drain_first && rewritten_q.size() > 0)) begin
               next_item = text_in_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.data_byte <= next_item.data_byte;
               req_if.is_final  <= next_item.is_final;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: stall pattern rotates and is replaced now and then
   logic [7:0] stall_bits = 8'h00;
   int         pattern_age = 0;
   result_type got;
   result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.out_byte, rsp_if.has_byte, rsp_if.run_last, rsp_if.stream_end};
            if (rewritten_q.size() == 0) begin
               $error("unexpected result: out_byte %02h has_byte %0b run_last %0b stream_end %0b",
                      got.out_byte, got.has_byte, got.run_last, got.stream_end);
               mismatch_count++;
            end else begin
               want = rewritten_q.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                  mismatch_count++;
               end
               if (got.has_byte !== want.has_byte) begin
                  $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
                  mismatch_count++;
               end
               if (got.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                  mismatch_count++;
               end
               if (got.stream_end !== want.stream_end) begin
                  $error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
                  mismatch_count++;
               end
            end
         end
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0: stall_bits = 8'h00;
               1: stall_bits = 8'($urandom_range(0, 255));
               2: stall_bits = 8'hFE;
               default: stall_bits = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
            endcase
         end else begin
            pattern_age--;
         end
         stall_bits = {stall_bits[0], stall_bits[7:1]};
         rsp_if.ready <= !stall_bits[0];
      end
   end

   task automatic queue_byte(logic [7:0] b, logic fin, bit drain);
      text_in_q.push_back('{b, fin, drain});
      items_queued++;
   endtask

   task automatic queue_text(string s, logic fin);
      for (int k = 0; k < s.len(); k++) queue_byte(s[k], fin && (k == s.len() - 1), 1'b0);
   endtask

   // Block until every transfer is done and the pipeline has settled
   task automatic wait_idle();
      while (text_in_q.size() != 0 || req_if.valid || rewritten_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         REG_SEARCH_LOW:   cfg_search_lo   = value;
         REG_SEARCH_HIGH:  cfg_search_hi   = value;
         REG_SEARCH_LEN:   cfg_search_len  = value[4:0];
         REG_REPLACE_LOW:  cfg_replace_lo  = value;
         REG_REPLACE_HIGH: cfg_replace_hi  = value;
         REG_REPLACE_LEN:  cfg_replace_len = value[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Length registers get random upper bits, which the block must ignore
   task automatic load_config(logic [127:0] search_str, logic [4:0] slen,
                              logic [127:0] replace_str, logic [4:0] rlen);
      logic [63:0] noise;
      wait_idle();
      csr_write(REG_SEARCH_LOW, search_str[63:0]);
      csr_write(REG_SEARCH_HIGH, search_str[127:64]);
      noise = {$urandom, $urandom};
      noise[4:0] = slen;
      csr_write(REG_SEARCH_LEN, noise);
      csr_write(REG_REPLACE_LOW, replace_str[63:0]);
      csr_write(REG_REPLACE_HIGH, replace_str[127:64]);
      noise = {$urandom, $urandom};
      noise[4:0] = rlen;
      csr_write(REG_REPLACE_LEN, noise);
   endtask

   // Stimulus
   initial begin
      logic [127:0] search_str;
      logic [127:0] replace_str;
      logic [4:0]   slen_raw;
      logic [4:0]   rlen_raw;
      logic [7:0]   alpha [3];
      logic [7:0]   chunk[$];
      logic [63:0]  len_word;
      int           slen_eff;
      int           stream_len;
      int           n_streams;
      int           cut;
      bit           ends_final;

      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.is_final  = 1'b0;
      rsp_if.ready     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: single zero byte deleted, empty end marker on a final zero byte
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'h5A, 1'b1, 1'b0);

      // Two-byte search, partial match then two hits, sender drains mid-stream
      load_config(128'h6261, 5'd2, 128'h5A5958, 5'd3);
      queue_text("aab", 1'b0);
      queue_byte("a", 1'b0, 1'b1);
      queue_byte("b", 1'b1, 1'b0);

      // Oversized lengths clamp to sixteen; full-width match with a final flush
      load_config({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 5'd31,
                  {64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF}, 5'd31);
      for (int k = 0; k < 16; k++) queue_byte((k < 8) ? 8'hFF : 8'h00, k == 15, 1'b0);

      // Search length shrunk to zero with a partly filled window
      load_config(128'h6463_6261, 5'd4, 128'h5150, 5'd2);
      queue_text("abc", 1'b0);
      wait_idle();
      len_word = {$urandom, $urandom};
      len_word[4:0] = 5'd0;
      csr_write(REG_SEARCH_LEN, len_word);
      queue_text("xa", 1'b1);

      // Random phases: small alphabet, mostly whole or partial search strings
      while (items_queued < 345) begin
         foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
         search_str = {$urandom, $urandom, $urandom, $urandom};
         for (int k = 0; k < 16; k++) search_str[8*k +: 8] = alpha[$urandom_range(0, 2)];
         case ($urandom_range(0, 9))
            0: slen_raw = 5'd0;
            1: slen_raw = 5'd16;
            2: slen_raw = 5'($urandom_range(17, 31));
            default: slen_raw = 5'($urandom_range(1, 6));
         endcase
         slen_eff = (slen_raw == 5'd0) ? 1 :
                    (slen_raw > MaxSearch) ? MaxSearch : int'(slen_raw);
         case ($urandom_range(0, 7))
            0: rlen_raw = 5'd0;
            1: rlen_raw = 5'($urandom_range(16, 31));
            default: rlen_raw = 5'($urandom_range(1, 5));
         endcase
         replace_str = {$urandom, $urandom, $urandom, $urandom};
         load_config(search_str, slen_raw, replace_str, rlen_raw);

         n_streams = $urandom_range(1, 3);
         for (int s = 0; s < n_streams; s++) begin
            chunk.delete();
            stream_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) :
                                                       $urandom_range(1, 20);
            while (chunk.size() < stream_len) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: begin
                     for (int k = 0; k < slen_eff; k++) chunk.push_back(search_str[8*k +: 8]);
                  end
                  5, 6: begin
                     cut = $urandom_range(1, slen_eff);
                     for (int k = 0; k < cut; k++) chunk.push_back(search_str[8*k +: 8]);
                  end
                  7, 8: chunk.push_back(alpha[$urandom_range(0, 2)]);
                  default: chunk.push_back(8'($urandom_range(0, 255)));
               endcase
            end
            // the last stream of a phase sometimes stays open across the next setting
            ends_final = !(s == n_streams - 1 && $urandom_range(0, 2) == 0);
            foreach (chunk[k])
               queue_byte(chunk[k], ends_final && (k == chunk.size() - 1),
                          (k == 0) && ($urandom_range(0, 3) == 0));
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("** stream_find_replace: PASSED **");
      end else begin
         $display("** stream_find_replace: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("** stream_find_replace: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
rtl/sfr_pkg.sv
rtl/sfr_ifs.sv
rtl/sfr_front.sv
rtl/sfr_cmd_queue.sv
rtl/sfr_back.sv
rtl/stream_find_replace.sv
tb/sv/tb_top.sv
